/* src/mea_pkg.sv */
package mea_pkg;

    localparam logic [1:0] MOD_NO_DISP = 2'b00;
    localparam logic [1:0] MOD_DISP8   = 2'b01;
    localparam logic [1:0] MOD_DISP16  = 2'b10;
    localparam logic [1:0] MOD_REG     = 2'b11;

    localparam logic [2:0] RM_BX_SI = 3'd0;
    localparam logic [2:0] RM_BX_DI = 3'd1;
    localparam logic [2:0] RM_BP_SI = 3'd2;
    localparam logic [2:0] RM_BP_DI = 3'd3;
    localparam logic [2:0] RM_SI    = 3'd4;
    localparam logic [2:0] RM_DI    = 3'd5;
    localparam logic [2:0] RM_BP    = 3'b110;
    localparam logic [2:0] RM_BX    = 3'd7;

    localparam logic [4:0] CLK_DIRECT   = 5'd6;
    localparam logic [4:0] CLK_ONE_REG  = 5'd5;
    localparam logic [4:0] CLK_FAST_TWO = 5'd7;
    localparam logic [4:0] CLK_SLOW_TWO = 5'd8;
    localparam logic [4:0] CLK_DISP_ADD = 5'd4;
    localparam logic [4:0] CLK_MIN_MEM  = 5'd5;

    localparam logic [1:0] DISP_NONE  = 2'd0;
    localparam logic [1:0] DISP_BYTE  = 2'd1;
    localparam logic [1:0] DISP_WORD  = 2'd2;

    typedef struct packed {
        logic        is_register;
        logic [15:0] base_a;
        logic [15:0] base_b;
        logic [15:0] disp;
        logic        stack_segment;
        logic [1:0]  disp_bytes;
        logic [4:0]  base_cycles;
        logic        word_op;
        logic [1:0]  transfers;
    } decode_t;

    typedef struct packed {
        logic        is_register;
        logic [15:0] effective_offset;
        logic        stack_segment;
        logic [1:0]  disp_bytes;
        logic [4:0]  base_cycles;
        logic        word_op;
        logic [1:0]  transfers;
    } address_t;

endpackage

/* src/modrm_effective_address_cycles_core.sv */
// 8086/8088 ModRM effective address unit, 16-bit addressing modes.
//
// Input channel (s_valid/s_ready): one beat carries the ModRM mod and r/m
// fields, both displacement bytes, BX, BP, SI and DI, the word flag and the
// transfer count. Result channel (m_valid/m_ready): one beat per input beat,
// in order, with the register flag, effective offset, default segment,
// displacement length, effective address timing and transfer penalty.
//
// cfg_wr_en/cfg_wr_data write the CPU select (1 = 8086, 0 = 8088) in the
// cycle the enable is high; change it only while the pipe is empty.
//
// An input beat passes three registered stages in order: decode, offset add,
// penalty and clock sum, the last stage being the output register.
// Throughput is one beat per cycle unless stalled. Each stage advances
// when it is empty or the stage after it moves, so a stalled receiver
// holds the result and the pipe fills behind it; s_ready drops only
// when all three stages are full.
// Synchronous active-low reset empties the pipe and selects 8086.
module modrm_effective_address_cycles_core
    import mea_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mod_field,
    input  logic [2:0]  s_rm_field,
    input  logic [7:0]  s_disp_low,
    input  logic [7:0]  s_disp_high,
    input  logic [15:0] s_bx_value,
    input  logic [15:0] s_bp_value,
    input  logic [15:0] s_si_value,
    input  logic [15:0] s_di_value,
    input  logic        s_word_op,
    input  logic [1:0]  s_transfers,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_register,
    output logic [15:0] m_effective_offset,
    output logic        m_stack_segment,
    output logic [1:0]  m_disp_bytes,
    output logic [4:0]  m_ea_cycles,
    output logic [3:0]  m_penalty_cycles
);

    logic     cpu_is_8086_reg;

    logic     s1_valid_reg;
    decode_t  s1_reg;
    decode_t  s1_next;
    logic     s2_valid_reg;
    address_t s2_reg;
    address_t s2_next;
    logic     s3_valid_reg;
    logic        s3_is_register_reg;
    logic [15:0] s3_offset_reg;
    logic        s3_stack_reg;
    logic [1:0]  s3_disp_bytes_reg;
    logic [4:0]  s3_ea_cycles_reg;
    logic [3:0]  s3_penalty_reg;
    logic [4:0]  s3_ea_cycles_next;
    logic [3:0]  s3_penalty_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic direct;
    logic has_disp;
    logic penalize;

    assign s3_ready = !s3_valid_reg || m_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_is_8086_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            cpu_is_8086_reg <= cfg_wr_data;
        end
    end

    // decode: operand select, displacement, base clocks
    always_comb begin
        direct   = (s_mod_field == MOD_NO_DISP) && (s_rm_field == RM_BP);
        has_disp = (s_mod_field == MOD_DISP8) || (s_mod_field == MOD_DISP16);

        s1_next               = '0;
        s1_next.is_register   = (s_mod_field == MOD_REG);
        s1_next.word_op       = s_word_op;
        s1_next.transfers     = s_transfers;

        case (s_mod_field)
            MOD_DISP8: begin
                s1_next.disp       = {{8{s_disp_low[7]}}, s_disp_low};
                s1_next.disp_bytes = DISP_BYTE;
            end
            MOD_DISP16: begin
                s1_next.disp       = {s_disp_high, s_disp_low};
                s1_next.disp_bytes = DISP_WORD;
            end
            default: begin
                s1_next.disp       = direct ? {s_disp_high, s_disp_low} : 16'd0;
                s1_next.disp_bytes = direct ? DISP_WORD : DISP_NONE;
            end
        endcase

        case (s_rm_field)
            RM_BX_SI: begin
                s1_next.base_a      = s_bx_value;
                s1_next.base_b      = s_si_value;
                s1_next.base_cycles = CLK_FAST_TWO;
            end
            RM_BX_DI: begin
                s1_next.base_a      = s_bx_value;
                s1_next.base_b      = s_di_value;
                s1_next.base_cycles = CLK_SLOW_TWO;
            end
            RM_BP_SI: begin
                s1_next.base_a        = s_bp_value;
                s1_next.base_b        = s_si_value;
                s1_next.stack_segment = 1'b1;
                s1_next.base_cycles   = CLK_SLOW_TWO;
            end
            RM_BP_DI: begin
                s1_next.base_a        = s_bp_value;
                s1_next.base_b        = s_di_value;
                s1_next.stack_segment = 1'b1;
                s1_next.base_cycles   = CLK_FAST_TWO;
            end
            RM_SI: begin
                s1_next.base_a      = s_si_value;
                s1_next.base_cycles = CLK_ONE_REG;
            end
            RM_DI: begin
                s1_next.base_a      = s_di_value;
                s1_next.base_cycles = CLK_ONE_REG;
            end
            RM_BP: begin
                s1_next.base_a        = direct ? 16'd0 : s_bp_value;
                s1_next.stack_segment = !direct;
                s1_next.base_cycles   = direct ? CLK_DIRECT : CLK_ONE_REG;
            end
            RM_BX: begin
                s1_next.base_a      = s_bx_value;
                s1_next.base_cycles = CLK_ONE_REG;
            end
            default: begin
                s1_next.base_a      = s_bx_value;
                s1_next.base_cycles = CLK_ONE_REG;
            end
        endcase

        if (has_disp) begin
            s1_next.base_cycles = s1_next.base_cycles + CLK_DISP_ADD;
        end

        // register operand: zero every memory field
        if (s1_next.is_register) begin
            s1_next.base_a        = '0;
            s1_next.base_b        = '0;
            s1_next.disp          = '0;
            s1_next.stack_segment = 1'b0;
            s1_next.disp_bytes    = DISP_NONE;
            s1_next.base_cycles   = '0;
            s1_next.word_op       = 1'b0;
        end
    end

    // offset add, modulo 65536
    always_comb begin
        s2_next.is_register      = s1_reg.is_register;
        s2_next.effective_offset = s1_reg.base_a + s1_reg.base_b + s1_reg.disp;
        s2_next.stack_segment    = s1_reg.stack_segment;
        s2_next.disp_bytes       = s1_reg.disp_bytes;
        s2_next.base_cycles      = s1_reg.base_cycles;
        s2_next.word_op          = s1_reg.word_op;
        s2_next.transfers        = s1_reg.transfers;
    end

    // transfer penalty and clock total
    always_comb begin
        penalize = s2_reg.word_op &&
                   (!cpu_is_8086_reg || s2_reg.effective_offset[0]);
        s3_penalty_next   = penalize ? {s2_reg.transfers, 2'b00} : 4'd0;
        s3_ea_cycles_next = s2_reg.base_cycles + {1'b0, s3_penalty_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s_valid) begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_is_register_reg <= s2_reg.is_register;
            s3_offset_reg      <= s2_reg.effective_offset;
            s3_stack_reg       <= s2_reg.stack_segment;
            s3_disp_bytes_reg  <= s2_reg.disp_bytes;
            s3_ea_cycles_reg   <= s3_ea_cycles_next;
            s3_penalty_reg     <= s3_penalty_next;
        end
    end

    assign m_valid            = s3_valid_reg;
    assign m_is_register      = s3_is_register_reg;
    assign m_effective_offset = s3_offset_reg;
    assign m_stack_segment    = s3_stack_reg;
    assign m_disp_bytes       = s3_disp_bytes_reg;
    assign m_ea_cycles        = s3_ea_cycles_reg;
    assign m_penalty_cycles   = s3_penalty_reg;

endmodule

/* src/mea_checker.sv */
module mea_checker
    import mea_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_is_register,
    input logic [15:0] m_effective_offset,
    input logic        m_stack_segment,
    input logic [1:0]  m_disp_bytes,
    input logic [4:0]  m_ea_cycles,
    input logic [3:0]  m_penalty_cycles
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_effective_offset)
                                && $stable(m_ea_cycles))
        else $error("stalled result beat changed");

    a_register_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_register |-> m_effective_offset == 16'd0
            && !m_stack_segment && m_disp_bytes == DISP_NONE
            && m_ea_cycles == 5'd0 && m_penalty_cycles == 4'd0)
        else $error("register operand with memory fields set");

    a_clock_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_register |->
            m_ea_cycles >= {1'b0, m_penalty_cycles} + CLK_MIN_MEM
            && m_penalty_cycles[1:0] == 2'b00)
        else $error("EA clocks inconsistent with penalty");

endmodule

bind modrm_effective_address_cycles_core mea_checker u_mea_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_is_register      (m_is_register),
    .m_effective_offset (m_effective_offset),
    .m_stack_segment    (m_stack_segment),
    .m_disp_bytes       (m_disp_bytes),
    .m_ea_cycles        (m_ea_cycles),
    .m_penalty_cycles   (m_penalty_cycles)
);
